// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the keyboard matrix modules.
// Both expect clk and an active-low rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Trigger at one edge implies the consequent at the next edge.
`define ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/kms_pkg.sv =====
// ----------------------------------------------------------------------------
// kms_pkg
// Types, codes and the fixed key table of the keyboard matrix scanner.
// ----------------------------------------------------------------------------
package kms_pkg;

  localparam int NUM_COLS = 15;
  localparam int COL_W    = $clog2(NUM_COLS);

  typedef enum logic [2:0] {
    CMD_PRESS   = 3'd0,
    CMD_RELEASE = 3'd1,
    CMD_COL_LO  = 3'd2,
    CMD_COL_HI  = 3'd3,
    CMD_READ    = 3'd4,
    CMD_READ_T0 = 3'd5,
    CMD_READ_T1 = 3'd6
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CLOSE,
    ST_DONE
  } state_t;

  // host key codes with special handling
  localparam logic [7:0] HOST_BACK      = 8'h08;
  localparam logic [7:0] HOST_SHIFT     = 8'h10;
  localparam logic [7:0] HOST_CAPS_LOCK = 8'h14;
  localparam logic [7:0] HOST_KANA      = 8'h15;
  localparam logic [7:0] HOST_INSERT    = 8'h2d;
  localparam logic [7:0] HOST_DELETE    = 8'h2e;
  localparam logic [7:0] CODE_CAPS      = 8'hfe;
  localparam logic [7:0] CODE_KANA      = 8'hff;

  localparam logic [7:0] KEY_TABLE [NUM_COLS][8] = '{
    '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h1b, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37},
    '{8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49},
    '{8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4a, 8'h4b},
    '{8'h5a, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4e, 8'h4d, 8'hbc},
    '{8'h38, 8'h39, 8'h30, 8'hbd, 8'hde, 8'hdc, 8'h13, 8'h00},
    '{8'h00, 8'h4f, 8'h50, 8'hc0, 8'hdb, 8'h2e, 8'h00, 8'h00},
    '{8'h00, 8'h4c, 8'hbb, 8'hba, 8'hdd, 8'h0d, 8'h00, 8'h00},
    '{8'h00, 8'h09, 8'h20, 8'hbe, 8'hbf, 8'he2, 8'h00, 8'h00},
    '{8'h24, 8'h67, 8'h64, 8'h61, 8'h60, 8'h25, 8'h00, 8'h00},
    '{8'h6f, 8'h68, 8'h65, 8'h62, 8'h00, 8'h27, 8'h00, 8'h00},
    '{8'h6a, 8'h69, 8'h66, 8'h63, 8'h26, 8'h28, 8'h00, 8'h00},
    '{8'h6d, 8'h6b, 8'h00, 8'h6e, 8'h00, 8'h6c, 8'h00, 8'h00},
    '{8'h00, 8'h70, 8'h71, 8'h72, 8'h73, 8'h74, 8'h00, 8'h00},
    '{8'h11, 8'h10, CODE_KANA, CODE_CAPS, 8'h12, 8'h00, 8'h00, 8'h00}
  };

  // rows behind a diode take no part in bridging
  localparam logic [7:0] DIODE_MASK [NUM_COLS] = '{
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h1f
  };

  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] key_code;
    logic [7:0] port_data;
  } kms_in_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq_level;
  } kms_out_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;
    logic iterate;
    logic advance;
    logic commit;
  } kms_ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic is_read;
    logic skip;
    logic settled;
    logic last_col;
    logic out_free;
  } kms_stat_t;

endpackage

// ===== sv/kms_dp.sv =====
// ----------------------------------------------------------------------------
// kms_dp
// Key map, lock toggles, column select, closure unit and result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module kms_dp
  import kms_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  kms_in_t   in_data,
  input  logic      cfg_wr_en,
  input  logic      cfg_wr_data,
  input  kms_ctl_t  ctl,
  output kms_stat_t st,
  output logic      out_valid,
  input  logic      out_ready,
  output kms_out_t  out_data
);

  logic [255:0]     host_keys_r;
  logic             caps_r, kana_r, mode_b_r;
  logic [15:0]      col_sel_r;
  cmd_t             cmd_r;
  logic [7:0]       rows_r [NUM_COLS];
  logic [7:0]       acc_r, reach_r;
  logic [COL_W-1:0] col_r;
  logic             fresh_r;
  logic             out_valid_r;
  kms_out_t         out_data_r;

  logic [255:0]     held;
  logic [7:0]       rows_comb [NUM_COLS];
  logic [7:0]       bridge [NUM_COLS];
  logic [7:0]       base, reach_nxt, rd_nxt;

  // held keys including derived ones and lock positions
  always_comb begin
    held = host_keys_r;
    if (held[HOST_INSERT]) begin
      held[HOST_SHIFT]  = 1'b1;
      held[HOST_DELETE] = 1'b1;
    end
    if (held[HOST_BACK]) begin
      held[HOST_DELETE] = 1'b1;
    end
    held[CODE_CAPS] = caps_r;
    held[CODE_KANA] = kana_r;
    held[0]         = 1'b0;
  end

  always_comb begin
    for (int i = 0; i < NUM_COLS; i++) begin
      for (int j = 0; j < 8; j++) begin
        rows_comb[i][j] = held[KEY_TABLE[i][j]];
      end
      bridge[i] = rows_r[i] & ~DIODE_MASK[i];
    end
  end

  // one bridging pass over all other columns
  always_comb begin
    base      = fresh_r ? (rows_r[col_r] & ~DIODE_MASK[col_r]) : reach_r;
    reach_nxt = base;
    for (int c = 0; c < NUM_COLS; c++) begin
      if ((COL_W'(c) != col_r) && ((bridge[c] & base) != 8'h00)) begin
        reach_nxt = reach_nxt | bridge[c];
      end
    end
  end

  always_comb begin
    case (cmd_r)
      CMD_READ:    rd_nxt = ~acc_r;
      CMD_READ_T0: rd_nxt = mode_b_r ? 8'h00 : 8'h01;
      CMD_READ_T1: rd_nxt = 8'h01;
      default:     rd_nxt = 8'h00;
    endcase
  end

  assign st.is_read  = (in_data.cmd == CMD_READ);
  assign st.skip     = col_sel_r[col_r];
  assign st.settled  = !fresh_r && (reach_nxt == reach_r);
  assign st.last_col = (col_r == COL_W'(NUM_COLS - 1));
  assign st.out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      host_keys_r <= '0;
      caps_r      <= 1'b0;
      kana_r      <= 1'b0;
      mode_b_r    <= 1'b0;
      col_sel_r   <= '0;
      col_r       <= '0;
      fresh_r     <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        mode_b_r <= cfg_wr_data;
      end
      if (ctl.accept) begin
        case (in_data.cmd)
          CMD_PRESS: begin
            host_keys_r[in_data.key_code] <= 1'b1;
            if (in_data.key_code == HOST_CAPS_LOCK) begin
              caps_r <= ~caps_r;
            end else if (in_data.key_code == HOST_KANA) begin
              kana_r <= ~kana_r;
            end
          end
          CMD_RELEASE: host_keys_r[in_data.key_code] <= 1'b0;
          CMD_COL_LO:  col_sel_r[7:0]  <= in_data.port_data;
          CMD_COL_HI:  col_sel_r[15:8] <= in_data.port_data;
          default: ;
        endcase
        col_r   <= '0;
        fresh_r <= 1'b1;
      end else if (ctl.advance) begin
        col_r   <= st.last_col ? '0 : col_r + COL_W'(1);
        fresh_r <= 1'b1;
      end else if (ctl.iterate) begin
        fresh_r <= 1'b0;
      end
      if (ctl.commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      cmd_r  <= in_data.cmd;
      rows_r <= rows_comb;
      acc_r  <= 8'h00;
    end else if (ctl.advance) begin
      if (!st.skip) begin
        acc_r <= acc_r | rows_r[col_r] | reach_r;
      end
    end else if (ctl.iterate) begin
      reach_r <= reach_nxt;
    end
    if (ctl.commit) begin
      out_data_r.read_data <= rd_nxt;
      out_data_r.irq_level <= col_sel_r[15];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `ASSERT_NEXT(a_press_sets_key, ctl.accept && in_data.cmd == CMD_PRESS,
               host_keys_r[$past(in_data.key_code)], "pressed key not recorded")
  `ASSERT_NEXT(a_skip_keeps_acc, ctl.advance && !ctl.accept && st.skip,
               acc_r == $past(acc_r), "deselected column changed accumulator")
  `ASSERT_ALWAYS(a_col_range, col_r <= COL_W'(NUM_COLS - 1), "column counter out of range")

endmodule

// ===== sv/kms_ctrl.sv =====
// ----------------------------------------------------------------------------
// kms_ctrl
// Sequencer: takes an item, walks the closure over the columns for a data read, commits.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module kms_ctrl
  import kms_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  kms_stat_t st,
  output kms_ctl_t  ctl
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.accept = 1'b1;
          state_nxt  = st.is_read ? ST_CLOSE : ST_DONE;
        end
      end
      ST_CLOSE: begin
        if (st.skip || st.settled) begin
          ctl.advance = 1'b1;
          if (st.last_col) begin
            state_nxt = ST_DONE;
          end
        end else begin
          ctl.iterate = 1'b1;
        end
      end
      ST_DONE: begin
        if (st.out_free) begin
          ctl.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  `ASSERT_NEXT(a_read_enters_close, state_r == ST_IDLE && in_valid && st.is_read,
               state_r == ST_CLOSE, "data read did not start closure")
  `ASSERT_NEXT(a_last_col_done, state_r == ST_CLOSE && st.last_col && (st.skip || st.settled),
               state_r == ST_DONE, "closure did not finish after last column")

endmodule

// ===== sv/key_matrix_scan_ghosting.sv =====
// ----------------------------------------------------------------------------
// key_matrix_scan_ghosting
// Keyboard matrix with phantom-key ghosting, one result per item.
// ----------------------------------------------------------------------------
// Each item gives exactly one result. Press, release, column writes and the
// T0/T1 reads pass through accept, then the result register. A data read
// also walks the closure between the two: a column whose select bit is high
// is skipped, and a selected column takes one bridging pass that also loads
// the column, then further passes while the reach still grows, until a pass
// finds it settled. The closure is done by a single bridging unit that ORs
// in every other non-diode column overlapping the current reach in one pass.
// A new item is taken once the previous one has reached the output register,
// even while that result still waits to be taken.
// irq_level reflects bit 7 of the last column-high write, after this item.
// ----------------------------------------------------------------------------
module key_matrix_scan_ghosting
  import kms_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  // item input
  input  logic     in_valid,
  output logic     in_ready,
  input  kms_in_t  in_data,
  // result output
  output logic     out_valid,
  input  logic     out_ready,
  output kms_out_t out_data,
  // mode register (1 = mode B)
  input  logic     cfg_wr_en,
  input  logic     cfg_wr_data
);

  kms_ctl_t  ctl;
  kms_stat_t st;

  // sequencer: idle / closure walk / commit
  kms_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .ctl      (ctl)
  );

  // key map, column select and bridging unit
  kms_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_data     (in_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .ctl         (ctl),
    .st          (st),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

endmodule
